// File: rtl/lnds_pkg.sv
// Shared constants and controller/datapath interface types.
package lnds_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int LEN_W        = 11;
    localparam int OUT_DATA_W   = 24;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // take the input transfer
        logic read;    // issue one store read and advance the scan index
        logic commit;  // store the element if the store has room and load the output register
    } lnds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;      // no stored elements in this sequence
        logic full;       // store holds MAX_ELEMENTS elements
        logic scan_last;  // current scan index is the last stored element
        logic out_free;   // output register can take a result this cycle
    } lnds_status_t;

endpackage

// File: rtl/lnds_ctrl.sv
// Controller state machine: sequences load, store scan and commit.
module lnds_ctrl
    import lnds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  lnds_status_t status,
    output lnds_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.full || status.empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.read = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read data is compared in this cycle
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lnds_datapath.sv
// Datapath: element stores, scan compare, counters and output register.
module lnds_datapath
    import lnds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lnds_cmd_t              cmd,
    output lnds_status_t           status,
    input  logic [VALUE_WIDTH-1:0] s_tdata,
    input  logic                   s_tuser,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    logic [VALUE_WIDTH-1:0] value_mem [MAX_ELEMENTS];
    logic [LEN_W-1:0]       length_mem [MAX_ELEMENTS];

    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic                          last_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic [LEN_W-1:0]              best_reg;
    logic [LEN_W-1:0]              prev_reg;
    logic [ADDR_W-1:0]             idx_reg;
    logic                          rd_vld_reg;
    logic signed [VALUE_WIDTH-1:0] rd_val_reg;
    logic [LEN_W-1:0]              rd_len_reg;

    logic                          out_vld_reg;
    logic [LEN_W-1:0]              out_len_reg;
    logic [LEN_W-1:0]              out_best_reg;
    logic                          out_ovf_reg;
    logic                          out_last_reg;

    logic                          full;
    logic [LEN_W-1:0]              new_len;
    logic [LEN_W-1:0]              new_best;
    logic [COUNT_W-1:0]            count_m1;

    assign full     = (count_reg >= COUNT_W'(MAX_ELEMENTS));
    assign new_len  = prev_reg + LEN_W'(1);
    assign new_best = (new_len > best_reg) ? new_len : best_reg;
    assign count_m1 = count_reg - COUNT_W'(1);

    assign status.empty     = (count_reg == '0);
    assign status.full      = full;
    assign status.scan_last = ({1'b0, idx_reg} == count_m1);
    assign status.out_free  = !out_vld_reg || m_tready;

    // Store write at commit, registered read during the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !full)
        begin
            value_mem[count_reg[ADDR_W-1:0]]  <= key_reg;
            length_mem[count_reg[ADDR_W-1:0]] <= new_len;
        end
        if (cmd.read)
        begin
            rd_val_reg <= value_mem[idx_reg];
            rd_len_reg <= length_mem[idx_reg];
        end
    end

    // Payload held with the item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            best_reg   <= '0;
            prev_reg   <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.read;
            if (cmd.load)
            begin
                prev_reg <= '0;
                idx_reg  <= '0;
                if (s_tuser)
                begin
                    count_reg <= '0;
                    best_reg  <= '0;
                end
            end
            else
            begin
                if (cmd.read)
                begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                end
                if (rd_vld_reg && (rd_val_reg <= key_reg) && (rd_len_reg > prev_reg))
                begin
                    prev_reg <= rd_len_reg;
                end
                if (cmd.commit && !full)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                    best_reg  <= new_best;
                end
            end
        end
    end

    // Output register: hold the result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_len_reg  <= full ? '0 : new_len;
            out_best_reg <= full ? best_reg : new_best;
            out_ovf_reg  <= full;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2 * LEN_W){1'b0}}, out_best_reg, out_len_reg};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/longest_nondecreasing_subsequence.sv
// Top level of the longest non-decreasing subsequence engine.
//
// Input stream (s_*): one transfer per sequence element. tdata carries the
// signed element value, tuser the start-of-sequence flag (clears the store
// and the running maximum before this element), tlast the final-element flag.
// Output stream (m_*): one transfer per input element. tdata carries the
// length ending at this element (0 if dropped) and the best length so far;
// tuser flags an element dropped because the store is full; tlast echoes
// the final-element flag.
// Scheduling: each element is scanned against every earlier stored element
// of its sequence (no scan when there are none or the store is full), one
// registered read per cycle of the value and length stores. The next element
// is accepted the cycle after the result is loaded into the output register,
// so elements are taken one at a time.
// Reset: the store is empty and the running maximum is zero; no clearing
// pass is needed since only written entries are ever read.
// Stall: the output register holds its result while m_tready is low; a new
// element is still accepted and scanned, and waits at commit until the
// output register frees up.
module longest_nondecreasing_subsequence
    import lnds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] s_tdata,   // [31:0] element_value
    input  logic                   s_tuser,   // [0] start_sequence
    input  logic                   s_tlast,   // final_element
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // [10:0] length_ending_here,
                                              // [21:11] best_length, [23:22] zero
    output logic                   m_tuser,   // [0] capacity_overflow
    output logic                   m_tlast    // sequence_done
);

    lnds_cmd_t    cmd;
    lnds_status_t status;

    // Sequence each element: load, scan stored elements, commit the result.
    lnds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the stores, best-length compare and output register.
    lnds_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/lnds_checker.sv
// Scoreboard for the longest non-decreasing subsequence engine: predicts and checks results.
`timescale 1ns / 1ps

module lnds_checker
    import lnds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] s_tdata,   // [31:0] element_value
    input  logic                   s_tuser,   // [0] start_sequence
    input  logic                   s_tlast,   // final_element
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,   // [10:0] length_ending_here,
                                              // [21:11] best_length, [23:22] zero
    input  logic                   m_tuser,   // [0] capacity_overflow
    input  logic                   m_tlast,   // sequence_done
    output int                     error_count,
    output int                     pending_results
);

    typedef struct packed {
        logic [LEN_W-1:0] length_here;
        logic [LEN_W-1:0] best;
        logic             overflow;
        logic             done;
    } lnds_result_t;

    // Local copy of the engine state.
    logic signed [VALUE_WIDTH-1:0] stored_value [MAX_ELEMENTS];
    logic [LEN_W-1:0]              stored_length [MAX_ELEMENTS];
    int unsigned                   stored_count;
    logic [LEN_W-1:0]              running_max;

    lnds_result_t expected_results [$];
    lnds_result_t oldest_result;

    initial error_count = 0;

    // Take one element into the local store and return the result it causes.
    function automatic lnds_result_t take_element(input logic new_seq,
                                                  input logic signed [VALUE_WIDTH-1:0] value,
                                                  input logic is_final);
        lnds_result_t     res;
        logic [LEN_W-1:0] best_prior;
        res = '0;
        res.done = is_final;
        if (new_seq) begin
            stored_count = 0;
            running_max  = '0;
        end
        if (stored_count >= MAX_ELEMENTS) begin
            res.overflow = 1'b1;
        end else begin
            best_prior = '0;
            for (int j = 0; j < stored_count; j++) begin
                if (stored_value[ADDR_W'(j)] <= value
                    && stored_length[ADDR_W'(j)] > best_prior)
                    best_prior = stored_length[ADDR_W'(j)];
            end
            res.length_here                     = best_prior + LEN_W'(1);
            stored_value[ADDR_W'(stored_count)]  = value;
            stored_length[ADDR_W'(stored_count)] = res.length_here;
            stored_count++;
            if (res.length_here > running_max)
                running_max = res.length_here;
        end
        res.best = running_max;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stored_count = 0;
            running_max  = '0;
            expected_results.delete();
            pending_results <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no element pending: m_tdata=%h", m_tdata);
                    error_count++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    check_field("length_ending_here", 32'(oldest_result.length_here),
                                32'(m_tdata[LEN_W-1:0]));
                    check_field("best_length", 32'(oldest_result.best),
                                32'(m_tdata[2*LEN_W-1:LEN_W]));
                    check_field("m_tdata padding", 32'd0,
                                32'(m_tdata[OUT_DATA_W-1:2*LEN_W]));
                    check_field("capacity_overflow", 32'(oldest_result.overflow), 32'(m_tuser));
                    check_field("sequence_done", 32'(oldest_result.done), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(take_element(s_tuser, s_tdata, s_tlast));
            pending_results <= expected_results.size();
        end
    end

endmodule

// File: tb/tb_longest_nondecreasing_subsequence.sv
// Testbench top for the longest non-decreasing subsequence engine: stimulus and verdict.
`timescale 1ns / 1ps

module tb_longest_nondecreasing_subsequence;
    import lnds_pkg::*;

    // Shapes of value runs inside a generated sequence.
    typedef enum logic [2:0] {
        VAL_FULL,
        VAL_NARROW,
        VAL_RISING,
        VAL_FALLING,
        VAL_EXTREME
    } value_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VALUE_WIDTH-1:0] s_tdata = '0;     // [31:0] element_value
    logic                   s_tuser = 1'b0;   // [0] start_sequence
    logic                   s_tlast = 1'b0;   // final_element
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // [10:0] length_ending_here,
                                              // [21:11] best_length, [23:22] zero
    logic                   m_tuser;          // [0] capacity_overflow
    logic                   m_tlast;          // sequence_done

    int error_count;
    int pending_results;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    longest_nondecreasing_subsequence DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lnds_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: drop m_tready at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Offer one element and hold it until the transfer happens. Leave tvalid
    // high afterward; the next call may lower it while idling, and a drain lowers it.
    task automatic send_element(input logic new_seq, input logic [31:0] value,
                                input logic is_final);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= new_seq;
        s_tlast  <= is_final;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off the sender until every outstanding result has come back.
    // Wait on the clock before each test so the count reflects the last transfer.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    function automatic logic [31:0] next_value(input value_style_t style,
                                               input logic [31:0] prev);
        logic [31:0] corners [5];
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001};
        case (style)
            VAL_NARROW:  return 32'($urandom_range(16)) - 32'd8;  // many equal values
            VAL_RISING:  return ($urandom_range(9) == 0) ? prev - $urandom_range(200)
                                                         : prev + $urandom_range(1000);
            VAL_FALLING: return prev - $urandom_range(1000);
            VAL_EXTREME: return corners[3'($urandom_range(4))];
            default:     return $urandom();
        endcase
    endfunction

    // Well-formed sequence: start flag on the first element, final flag on the last.
    task automatic send_sequence(input int count);
        value_style_t style;
        logic [31:0]  value;
        style = value_style_t'($urandom_range(VAL_EXTREME));
        value = $urandom();
        for (int i = 0; i < count; i++) begin
            value = next_value(style, value);
            send_element(i == 0, value, i == count - 1);
        end
    endtask

    // Broken framing: start and final flags at random, so elements append
    // after a final or a sequence restarts without one.
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_element($urandom_range(3) == 0, $urandom(), $urandom_range(2) == 0);
    endtask

    task automatic run_random(input int quota);
        int sent;
        int count;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99) < 6)
                wait_for_drain();
            if ($urandom_range(99) < 85) begin
                // mostly short sequences, now and then a longer scan
                count = ($urandom_range(11) == 0) ? $urandom_range(25, 100)
                                                  : $urandom_range(1, 24);
                send_sequence(count);
            end else begin
                count = $urandom_range(1, 5);
                send_noise(count);
            end
            sent += count;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: sender idles often, receiver idles most of the time.
        sender_idle_pct   =  37;
        receiver_idle_pct <= 77;
        @(posedge clk);

        // Directed: no start after reset, equal values, extremes, appending
        // after a final, restart without a final, single-element sequence.
        send_element(1'b0, 32'd5,          1'b0);
        send_element(1'b0, 32'd5,          1'b0);
        send_element(1'b0, 32'h8000_0000,  1'b0);
        send_element(1'b0, 32'h7fff_ffff,  1'b1);
        send_element(1'b0, 32'h0000_0000,  1'b0);
        send_element(1'b0, 32'hffff_ffff,  1'b1);
        send_element(1'b1, 32'hffff_ffff,  1'b0);
        send_element(1'b0, 32'h0000_0001,  1'b0);
        send_element(1'b0, 32'h0000_0000,  1'b0);
        send_element(1'b0, 32'h5555_5555,  1'b0);
        send_element(1'b0, 32'haaaa_aaaa,  1'b0);
        send_element(1'b0, 32'h8000_0000,  1'b0);
        send_element(1'b0, 32'h7fff_ffff,  1'b1);
        send_element(1'b1, 32'h1234_5678,  1'b1);
        send_element(1'b1, 32'h7fff_ffff,  1'b0);
        send_element(1'b1, 32'd3,          1'b0);
        send_element(1'b0, 32'd3,          1'b0);
        send_element(1'b0, 32'd4,          1'b0);
        send_element(1'b0, 32'd2,          1'b0);
        send_element(1'b0, 32'd3,          1'b1);
        wait_for_drain();

        run_random(180);

        // Phase two: swap the idle rates.
        wait_for_drain();
        sender_idle_pct   =  77;
        receiver_idle_pct <= 37;
        run_random(180);

        // Phase three: no idling on either side.
        wait_for_drain();
        sender_idle_pct   =  0;
        receiver_idle_pct <= 0;
        run_random(160);

        // Wait out all results, then allow for a stray late transfer.
        wait_for_drain();
        repeat (1100) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
